[hdl/gpr_pkg.sv]
`timescale 1ns / 1ps

package gpr_pkg;

   localparam int GRID_SIZE_DEFAULT = 32;

   localparam int KIND_W  = 3;
   localparam int COUNT_W = 8;
   localparam int COORD_W = 5;

   localparam logic [KIND_W-1:0] KIND_UP    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_NOP,
      OP_MOVE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type               op;
      logic                 axis_row;
      logic                 dec;
      logic [COUNT_W-1:0]   count;
      logic [COORD_W-1:0]   rd_row;
      logic [COORD_W-1:0]   rd_col;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_MOVE,
      BK_READ
   } back_state_type;

endpackage

[hdl/gpr_queue.sv]
`timescale 1ns / 1ps

module gpr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gpr_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output gpr_pkg::cmd_type           head_cmd,
   output logic                       head_valid,
   output gpr_pkg::queue_status_type  q_status
);
   import gpr_pkg::*;

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QCW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd      = entry_ff[rd_ptr_ff];
   assign head_valid    = (fill_ff != '0);
   assign q_status.full = (fill_ff == QCW'(QUEUE_DEPTH));

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == QCW'(QUEUE_DEPTH)) |-> !push)
      else $error("Command pushed into a full queue.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> !pop)
      else $error("Command popped from an empty queue.");

endmodule

[hdl/gpr_front.sv]
`timescale 1ns / 1ps

module gpr_front #(
   parameter int GRID_SIZE = gpr_pkg::GRID_SIZE_DEFAULT
) (
   input  logic                          start,
   output logic                          busy,
   input  logic [gpr_pkg::KIND_W-1:0]    req_kind,
   input  logic [gpr_pkg::COUNT_W-1:0]   req_count,
   input  logic [gpr_pkg::COORD_W-1:0]   req_read_row,
   input  logic [gpr_pkg::COORD_W-1:0]   req_read_col,
   input  gpr_pkg::back_status_type      bk_status,
   input  gpr_pkg::queue_status_type     q_status,
   output logic                          push,
   output gpr_pkg::cmd_type              push_cmd
);
   import gpr_pkg::*;

   logic    read_in_range;
   logic    count_nonzero;
   cmd_type cmd;

   assign read_in_range = (int'(req_read_row) < GRID_SIZE) && (int'(req_read_col) < GRID_SIZE);
   assign count_nonzero = (req_count != '0);

   always_comb begin
      cmd          = '0;
      cmd.op       = OP_NOP;
      cmd.count    = req_count;
      cmd.rd_row   = req_read_row;
      cmd.rd_col   = req_read_col;
      case (req_kind)
         KIND_UP: begin
            cmd.op       = count_nonzero ? OP_MOVE : OP_NOP;
            cmd.axis_row = 1'b1;
            cmd.dec      = 1'b1;
         end
         KIND_DOWN: begin
            cmd.op       = count_nonzero ? OP_MOVE : OP_NOP;
            cmd.axis_row = 1'b1;
            cmd.dec      = 1'b0;
         end
         KIND_RIGHT: begin
            cmd.op       = count_nonzero ? OP_MOVE : OP_NOP;
            cmd.axis_row = 1'b0;
            cmd.dec      = 1'b0;
         end
         KIND_LEFT: begin
            cmd.op       = count_nonzero ? OP_MOVE : OP_NOP;
            cmd.axis_row = 1'b0;
            cmd.dec      = 1'b1;
         end
         KIND_READ: begin
            cmd.op = read_in_range ? OP_READ : OP_NOP;
         end
         default: begin
            cmd.op = OP_NOP;
         end
      endcase
   end

   assign busy     = q_status.full | bk_status.clearing;
   assign push     = start & ~busy;
   assign push_cmd = cmd;

endmodule

[hdl/gpr_back.sv]
`timescale 1ns / 1ps

module gpr_back #(
   parameter int GRID_SIZE = gpr_pkg::GRID_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gpr_pkg::cmd_type              head_cmd,
   input  logic                          head_valid,
   output logic                          pop,
   output gpr_pkg::back_status_type      bk_status,
   output logic                          rsp_valid,
   output logic [gpr_pkg::COORD_W-1:0]   rsp_pen_row,
   output logic [gpr_pkg::COORD_W-1:0]   rsp_pen_col,
   output logic                          rsp_hit_edge,
   output logic                          rsp_cell_marked
);
   import gpr_pkg::*;

   localparam int PW    = $clog2(GRID_SIZE);
   localparam int CW    = $clog2(GRID_SIZE + 1);
   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);

   back_state_type      state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [PW-1:0]       row_ff, row_in;
   logic [PW-1:0]       col_ff, col_in;
   logic [CW-1:0]       left_ff, left_in;
   logic                axis_row_ff, axis_row_in;
   logic                dec_ff, dec_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COORD_W-1:0]  rsp_col_ff, rsp_col_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_marked_ff, rsp_marked_in;
   logic                rd_data_ff;

   logic                canvas_mem [CELLS];
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic                mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;

   logic [PW-1:0]       pos;
   logic [CW-1:0]       avail;
   logic                over;
   logic [CW-1:0]       run_len;
   logic [AW-1:0]       pen_addr;

   assign pos      = head_cmd.axis_row ? row_ff : col_ff;
   assign avail    = head_cmd.dec ? (CW'(pos) + CW'(1)) : (CW'(GRID_SIZE) - CW'(pos));
   assign over     = (COUNT_W'(avail) < head_cmd.count);
   assign run_len  = over ? avail : CW'(head_cmd.count);
   assign pen_addr = AW'(row_ff) * AW'(GRID_SIZE) + AW'(col_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_addr_ff == AW'(CELLS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (head_valid) begin
               case (head_cmd.op)
                  OP_MOVE: state_in = BK_MOVE;
                  OP_READ: state_in = BK_READ;
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_MOVE: begin
            if (left_ff == CW'(1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_READ: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_comb begin
      clr_addr_in   = clr_addr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      left_in       = left_ff;
      axis_row_in   = axis_row_ff;
      dec_in        = dec_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_row_in    = COORD_W'(row_ff);
      rsp_col_in    = COORD_W'(col_ff);
      rsp_hit_in    = 1'b0;
      rsp_marked_in = 1'b0;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = pen_addr;
      mem_wdata     = 1'b1;
      mem_re        = 1'b0;
      mem_raddr     = AW'(head_cmd.rd_row) * AW'(GRID_SIZE) + AW'(head_cmd.rd_col);
      case (state_ff)
         BK_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = 1'b0;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         BK_IDLE: begin
            if (head_valid) begin
               pop         = 1'b1;
               axis_row_in = head_cmd.axis_row;
               dec_in      = head_cmd.dec;
               left_in     = run_len;
               hit_in      = over;
               case (head_cmd.op)
                  OP_READ: mem_re = 1'b1;
                  OP_MOVE: mem_re = 1'b0;
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         BK_MOVE: begin
            mem_we  = 1'b1;
            left_in = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
            end else if (axis_row_ff) begin
               row_in = dec_ff ? (row_ff - PW'(1)) : (row_ff + PW'(1));
            end else begin
               col_in = dec_ff ? (col_ff - PW'(1)) : (col_ff + PW'(1));
            end
         end
         BK_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_marked_in = rd_data_ff;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         left_ff      <= '0;
         axis_row_ff  <= 1'b0;
         dec_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         left_ff      <= left_in;
         axis_row_ff  <= axis_row_in;
         dec_ff       <= dec_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_marked_ff <= rsp_marked_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= canvas_mem[mem_raddr];
      end
   end

   assign bk_status.clearing = (state_ff == BK_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pen_row        = rsp_row_ff;
   assign rsp_pen_col        = rsp_col_ff;
   assign rsp_hit_edge       = rsp_hit_ff;
   assign rsp_cell_marked    = rsp_marked_ff;

   a_quiet_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !rsp_valid_ff)
      else $error("Result issued during the canvas clearing pass.");

   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ) |=> rsp_valid_ff)
      else $error("Cell read did not produce a result.");

   a_run_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_MOVE && left_ff == CW'(1)) |=> (rsp_valid_ff && state_ff == BK_IDLE))
      else $error("Finished run did not produce a result.");

   a_pen_on_canvas: assert property (@(posedge clock) disable iff (reset)
      (int'(row_ff) < GRID_SIZE) && (int'(col_ff) < GRID_SIZE))
      else $error("Pen left the canvas.");

endmodule

[hdl/grid_pen_run_painter.sv]
`timescale 1ns / 1ps
// Pen plotter on a GRID_SIZE x GRID_SIZE one-bit canvas.
// An item is taken at a rising edge where start is high and busy is low, with its
// fields on the req_ ports. A move marks up to count cells from the pen's cell in
// one direction and stops at the canvas edge, setting the hit flag when cut short.
// A read returns one cell. Every item gives exactly one result beat: rsp_valid is
// high for one cycle with the pen position, the hit flag and the cell bit.
// Items are classified at the front and held in a two-entry command queue, so a
// new item is taken while the executor is still painting.
// The executor writes one canvas cell per cycle through a single write port.
// The executor pops each item in its idle state. A move then marks its cells in
// the move state and gives the result after the last cell; a read starts the
// memory read in the idle state and gives the result from the read state; any
// other item gets its result from the idle state. All results are registered.
// After reset the pen is at row 0, column 0 and the canvas is cleared one cell a
// cycle, with busy high until the last cell is cleared.
// The receiver cannot stall: each result beat is taken in the cycle it is shown.
module grid_pen_run_painter #(
   parameter int GRID_SIZE = gpr_pkg::GRID_SIZE_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gpr_pkg::KIND_W-1:0]    req_kind,
   input  logic [gpr_pkg::COUNT_W-1:0]   req_count,
   input  logic [gpr_pkg::COORD_W-1:0]   req_read_row,
   input  logic [gpr_pkg::COORD_W-1:0]   req_read_col,
   output logic                          rsp_valid,
   output logic [gpr_pkg::COORD_W-1:0]   rsp_pen_row,
   output logic [gpr_pkg::COORD_W-1:0]   rsp_pen_col,
   output logic                          rsp_hit_edge,
   output logic                          rsp_cell_marked
);
   import gpr_pkg::*;

   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   cmd_type           head_cmd;
   logic              head_valid;
   queue_status_type  q_status;
   back_status_type   bk_status;

   gpr_front #(
      .GRID_SIZE (GRID_SIZE)
   ) u_front (
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_count    (req_count),
      .req_read_row (req_read_row),
      .req_read_col (req_read_col),
      .bk_status    (bk_status),
      .q_status     (q_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   gpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .q_status   (q_status)
   );

   gpr_back #(
      .GRID_SIZE (GRID_SIZE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .head_valid      (head_valid),
      .pop             (pop),
      .bk_status       (bk_status),
      .rsp_valid       (rsp_valid),
      .rsp_pen_row     (rsp_pen_row),
      .rsp_pen_col     (rsp_pen_col),
      .rsp_hit_edge    (rsp_hit_edge),
      .rsp_cell_marked (rsp_cell_marked)
   );

endmodule
